// File: rtl/core/ean_pkg.sv
// Shared types, code tables and helpers for the EAN/UPC bar-module encoder.
// No dependencies; used by ean_ctrl, ean_datapath and the top level.
package ean_pkg;

  typedef enum logic [1:0] {
    SYM_EAN13 = 2'd0,
    SYM_UPCA  = 2'd1,
    SYM_EAN8  = 2'd2,
    SYM_UPCE  = 2'd3
  } sym_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_LEN   = 3'd1,
    ST_NON_DIGIT = 3'd2,
    ST_MISMATCH  = 3'd3,
    ST_BAD_SYS   = 3'd4
  } status_e;

  localparam int unsigned StoreDepth = 13;

  localparam logic [6:0] GuardPat   = 7'h05;
  localparam logic [6:0] CenterPat  = 7'h0A;
  localparam logic [6:0] UpceEndPat = 7'h15;

  localparam logic [2:0] GuardCnt   = 3'd3;
  localparam logic [2:0] CenterCnt  = 3'd5;
  localparam logic [2:0] UpceEndCnt = 3'd6;
  localparam logic [2:0] DigitCnt   = 3'd7;

  // controller -> datapath
  typedef struct packed {
    logic load;        // store one digit beat
    logic start_code;  // marked digit taken: clear iteration state
    logic sum;         // one checksum step
    logic decide;      // latch verdict and check digit
    logic emit;        // put out one group
  } ean_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sum_done;
    logic emit_last;
  } ean_sts_t;

  function automatic logic [6:0] code_l(input logic [3:0] d);
    logic [6:0] r;
    case (d)
      4'd0: r = 7'h0D;
      4'd1: r = 7'h19;
      4'd2: r = 7'h13;
      4'd3: r = 7'h3D;
      4'd4: r = 7'h23;
      4'd5: r = 7'h31;
      4'd6: r = 7'h2F;
      4'd7: r = 7'h3B;
      4'd8: r = 7'h37;
      4'd9: r = 7'h0B;
      default: r = 7'h00;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] code_g(input logic [3:0] d);
    logic [6:0] r;
    case (d)
      4'd0: r = 7'h27;
      4'd1: r = 7'h33;
      4'd2: r = 7'h1B;
      4'd3: r = 7'h21;
      4'd4: r = 7'h1D;
      4'd5: r = 7'h39;
      4'd6: r = 7'h05;
      4'd7: r = 7'h11;
      4'd8: r = 7'h09;
      4'd9: r = 7'h17;
      default: r = 7'h00;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] code_r(input logic [3:0] d);
    logic [6:0] r;
    case (d)
      4'd0: r = 7'h72;
      4'd1: r = 7'h66;
      4'd2: r = 7'h6C;
      4'd3: r = 7'h42;
      4'd4: r = 7'h5C;
      4'd5: r = 7'h4E;
      4'd6: r = 7'h50;
      4'd7: r = 7'h44;
      4'd8: r = 7'h48;
      4'd9: r = 7'h74;
      default: r = 7'h00;
    endcase
    return r;
  endfunction

  // left-half parity, bit 5 = first left digit, 1 = G pattern
  function automatic logic [5:0] par_ean(input logic [3:0] d);
    logic [5:0] r;
    case (d)
      4'd0: r = 6'h00;
      4'd1: r = 6'h0B;
      4'd2: r = 6'h0D;
      4'd3: r = 6'h0E;
      4'd4: r = 6'h13;
      4'd5: r = 6'h19;
      4'd6: r = 6'h1C;
      4'd7: r = 6'h15;
      4'd8: r = 6'h16;
      4'd9: r = 6'h1A;
      default: r = 6'h00;
    endcase
    return r;
  endfunction

  // UPC-E parity for number system 0; system 1 takes the complement
  function automatic logic [5:0] par_upce(input logic [3:0] d);
    logic [5:0] r;
    case (d)
      4'd0: r = 6'h38;
      4'd1: r = 6'h34;
      4'd2: r = 6'h32;
      4'd3: r = 6'h31;
      4'd4: r = 6'h2C;
      4'd5: r = 6'h26;
      4'd6: r = 6'h23;
      4'd7: r = 6'h2A;
      4'd8: r = 6'h29;
      4'd9: r = 6'h25;
      default: r = 6'h00;
    endcase
    return r;
  endfunction

  // remainder by ten for a 6-bit value
  function automatic logic [3:0] mod10(input logic [5:0] v);
    logic [5:0] r;
    r = v;
    if (r >= 6'd60)      r = r - 6'd60;
    else if (r >= 6'd50) r = r - 6'd50;
    else if (r >= 6'd40) r = r - 6'd40;
    else if (r >= 6'd30) r = r - 6'd30;
    else if (r >= 6'd20) r = r - 6'd20;
    else if (r >= 6'd10) r = r - 6'd10;
    return r[3:0];
  endfunction

endpackage

// File: rtl/core/ean_ctrl.sv
// Sequencer of the bar-module encoder: load, checksum sweep, verdict, emission.
// Depends on ean_pkg for the command and status structs.
module ean_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              last_digit_i,
  input  ean_pkg::ean_sts_t sts_i,
  output ean_pkg::ean_cmd_t cmd_o,
  output logic              busy_o
);
  import ean_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SUM    = 4'b0010,
    S_DECIDE = 4'b0100,
    S_EMIT   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (last_digit_i) begin
            cmd_o.start_code = 1'b1;
            state_d = S_SUM;
          end
        end
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        if (sts_i.sum_done) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        if (sts_i.emit_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

endmodule

// File: rtl/core/ean_datapath.sv
// Digit store, checksum accumulator, verdict and group generator with output
// registers. Depends on ean_pkg for code tables, command and status structs.
module ean_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              symbology_we_i,
  input  logic [1:0]        symbology_i,
  input  logic [3:0]        digit_i,
  input  ean_pkg::ean_cmd_t cmd_i,
  output ean_pkg::ean_sts_t sts_o,
  output logic              result_valid_o,
  output logic [6:0]        modules_o,
  output logic [2:0]        module_count_o,
  output logic              full_height_o,
  output logic [2:0]        status_o,
  output logic [3:0]        check_value_o,
  output logic              last_group_o
);
  import ean_pkg::*;

  sym_e       sym_q;
  logic [3:0] store_q [StoreDepth];
  logic [3:0] count_q;
  logic       non_digit_q;
  logic [3:0] idx_q;
  logic [3:0] acc_q;
  logic       err_q;
  status_e    status_q;
  logic [3:0] chk_q;

  logic       valid_q;
  logic [6:0] mods_q;
  logic [2:0] mcnt_q;
  logic       full_q;
  logic       last_q;

  // read port into the digit store, shared by the checksum sweep and emission
  logic [3:0] rd_addr;
  logic [3:0] rd_data;
  logic [3:0] emit_addr;

  always_comb begin
    rd_addr = cmd_i.sum ? idx_q : emit_addr;
    rd_data = (rd_addr < 4'(StoreDepth)) ? store_q[rd_addr] : 4'd0;
  end

  // checksum step
  logic [3:0] sum_limit;
  logic       w3;
  logic [5:0] term;

  always_comb begin
    case (sym_q)
      SYM_EAN13: begin sum_limit = 4'd12; w3 = idx_q[0];  end
      SYM_UPCA:  begin sum_limit = 4'd11; w3 = ~idx_q[0]; end
      SYM_EAN8:  begin sum_limit = 4'd7;  w3 = ~idx_q[0]; end
      default:   begin sum_limit = 4'd0;  w3 = 1'b0;      end
    endcase
    if (idx_q >= sum_limit) term = 6'd0;
    else if (w3)            term = {1'b0, rd_data, 1'b0} + 6'(rd_data);
    else                    term = 6'(rd_data);
  end

  // verdict
  logic [3:0] chk_calc;
  logic       len_bad;
  logic       mismatch;
  status_e    status_d;
  logic [3:0] chk_d;

  always_comb begin
    chk_calc = (acc_q == 4'd0) ? 4'd0 : 4'(4'd10 - acc_q);
    case (sym_q)
      SYM_EAN13: begin
        len_bad  = !(count_q == 4'd12 || count_q == 4'd13);
        mismatch = (count_q == 4'd13) && (store_q[12] != chk_calc);
      end
      SYM_UPCA: begin
        len_bad  = !(count_q == 4'd11 || count_q == 4'd12);
        mismatch = (count_q == 4'd12) && (store_q[11] != chk_calc);
      end
      SYM_EAN8: begin
        len_bad  = !(count_q == 4'd7 || count_q == 4'd8);
        mismatch = (count_q == 4'd8) && (store_q[7] != chk_calc);
      end
      default: begin
        len_bad  = (count_q != 4'd8);
        mismatch = 1'b0;
      end
    endcase
    chk_d    = chk_calc;
    status_d = ST_OK;
    if (len_bad) begin
      status_d = ST_BAD_LEN;
      chk_d    = 4'd0;
    end else if (non_digit_q) begin
      status_d = ST_NON_DIGIT;
      chk_d    = 4'd0;
    end else if (sym_q == SYM_UPCE) begin
      if (store_q[0] > 4'd1) begin
        status_d = ST_BAD_SYS;
        chk_d    = 4'd0;
      end else begin
        chk_d = store_q[7];
      end
    end else if (mismatch) begin
      status_d = ST_MISMATCH;
    end
  end

  // group generator
  logic [6:0] grp_pat;
  logic [2:0] grp_cnt;
  logic       grp_full;
  logic       use_chk;
  logic       left_digit;
  logic       right_digit;
  logic [5:0] par;
  logic [2:0] pidx;
  logic [3:0] dsel;
  logic [3:0] last_idx;

  always_comb begin
    grp_pat     = GuardPat;
    grp_cnt     = GuardCnt;
    grp_full    = 1'b1;
    use_chk     = 1'b0;
    left_digit  = 1'b0;
    right_digit = 1'b0;
    emit_addr   = idx_q;
    pidx        = 3'(4'd6 - idx_q);
    par         = 6'd0;
    case (sym_q)
      SYM_EAN13, SYM_UPCA: begin
        last_idx = 4'd14;
        par      = (sym_q == SYM_UPCA) ? 6'd0 : par_ean(store_q[0]);
        if (idx_q == 4'd7) begin
          grp_pat = CenterPat;
          grp_cnt = CenterCnt;
        end else if (idx_q >= 4'd1 && idx_q <= 4'd6) begin
          left_digit = 1'b1;
          emit_addr  = (sym_q == SYM_UPCA) ? idx_q - 4'd1 : idx_q;
          grp_full   = (sym_q == SYM_UPCA) && (idx_q == 4'd1);
        end else if (idx_q >= 4'd8 && idx_q <= 4'd13) begin
          right_digit = 1'b1;
          use_chk     = (idx_q == 4'd13);
          emit_addr   = (sym_q == SYM_UPCA) ? idx_q - 4'd2 : idx_q - 4'd1;
          grp_full    = (sym_q == SYM_UPCA) && (idx_q == 4'd13);
        end
      end
      SYM_EAN8: begin
        last_idx = 4'd10;
        if (idx_q == 4'd5) begin
          grp_pat = CenterPat;
          grp_cnt = CenterCnt;
        end else if (idx_q >= 4'd1 && idx_q <= 4'd4) begin
          left_digit = 1'b1;
          emit_addr  = idx_q - 4'd1;
          grp_full   = 1'b0;
        end else if (idx_q >= 4'd6 && idx_q <= 4'd9) begin
          right_digit = 1'b1;
          use_chk     = (idx_q == 4'd9);
          emit_addr   = idx_q - 4'd2;
          grp_full    = 1'b0;
        end
      end
      default: begin
        last_idx = 4'd7;
        // number system 1 flips the parity pattern
        par = (store_q[0] == 4'd1) ? ~par_upce(store_q[7]) : par_upce(store_q[7]);
        if (idx_q == 4'd7) begin
          grp_pat = UpceEndPat;
          grp_cnt = UpceEndCnt;
        end else if (idx_q >= 4'd1 && idx_q <= 4'd6) begin
          left_digit = 1'b1;
          grp_full   = 1'b0;
        end
      end
    endcase
    dsel = use_chk ? chk_q : rd_data;
    if (left_digit) begin
      grp_cnt = DigitCnt;
      grp_pat = par[pidx] ? code_g(dsel) : code_l(dsel);
    end else if (right_digit) begin
      grp_cnt = DigitCnt;
      grp_pat = code_r(dsel);
    end
  end

  assign sts_o.sum_done  = (idx_q == 4'(StoreDepth - 1));
  assign sts_o.emit_last = err_q || (idx_q == last_idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_q       <= SYM_EAN13;
      count_q     <= 4'd0;
      non_digit_q <= 1'b0;
      idx_q       <= 4'd0;
      valid_q     <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
      if (symbology_we_i) sym_q <= sym_e'(symbology_i);
      if (cmd_i.load) begin
        if (count_q != 4'd15) count_q <= count_q + 4'd1;
        if (digit_i > 4'd9)   non_digit_q <= 1'b1;
      end
      if (cmd_i.start_code || cmd_i.decide) idx_q <= 4'd0;
      else if (cmd_i.sum || cmd_i.emit)     idx_q <= idx_q + 4'd1;
      // drop the entry once its last group is out
      if (cmd_i.emit && sts_o.emit_last) begin
        count_q     <= 4'd0;
        non_digit_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && count_q < 4'(StoreDepth)) store_q[count_q] <= digit_i;
    if (cmd_i.start_code) acc_q <= 4'd0;
    else if (cmd_i.sum)   acc_q <= mod10(6'(acc_q) + term);
    if (cmd_i.decide) begin
      status_q <= status_d;
      chk_q    <= chk_d;
      err_q    <= (status_d != ST_OK);
    end
    if (cmd_i.emit) begin
      if (err_q) begin
        mods_q <= 7'd0;
        mcnt_q <= 3'd0;
        full_q <= 1'b0;
      end else begin
        mods_q <= grp_pat;
        mcnt_q <= grp_cnt;
        full_q <= grp_full;
      end
      last_q <= sts_o.emit_last;
    end
  end

  assign result_valid_o = valid_q;
  assign modules_o      = mods_q;
  assign module_count_o = mcnt_q;
  assign full_height_o  = full_q;
  assign status_o       = status_q;
  assign check_value_o  = chk_q;
  assign last_group_o   = last_q;

endmodule

// File: rtl/core/ean_upc_barcode_module_encoder_core.sv
// Top level of the EAN-13 / UPC-A / EAN-8 / UPC-E bar-module encoder.
// Depends on ean_pkg, ean_ctrl and ean_datapath.
//
//  port group       dir  handshake                  payload
//  digit beat       in   start_i & !busy_o          digit_i, last_digit_i
//  result beat      out  result_valid_o (1 cycle)   modules_o .. last_group_o
//  symbology write  in   symbology_we_i             symbology_i
//
// Each unmarked digit is stored as it is taken. The marked digit starts a checksum
// sweep over the digit store through its shared read port, a verdict step, then
// one group per cycle (15 EAN-13/UPC-A, 11 EAN-8, 8 UPC-E, or one error beat);
// each group is shown in the cycle after it is built. Reset clears the control
// state and the symbology to EAN-13. busy_o is high from the marked digit to
// the final group; the receiver cannot stall.
module ean_upc_barcode_module_encoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [3:0] digit_i,
  input  logic       last_digit_i,
  input  logic       symbology_we_i,
  input  logic [1:0] symbology_i,
  output logic       result_valid_o,
  output logic [6:0] modules_o,
  output logic [2:0] module_count_o,
  output logic       full_height_o,
  output logic [2:0] status_o,
  output logic [3:0] check_value_o,
  output logic       last_group_o
);
  import ean_pkg::*;

  ean_cmd_t cmd;
  ean_sts_t sts;

  ean_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .last_digit_i (last_digit_i),
    .sts_i        (sts),
    .cmd_o        (cmd),
    .busy_o       (busy_o)
  );

  ean_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .symbology_we_i (symbology_we_i),
    .symbology_i    (symbology_i),
    .digit_i        (digit_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_valid_o (result_valid_o),
    .modules_o      (modules_o),
    .module_count_o (module_count_o),
    .full_height_o  (full_height_o),
    .status_o       (status_o),
    .check_value_o  (check_value_o),
    .last_group_o   (last_group_o)
  );

endmodule

// File: tb/tb_top.sv
// Self-checking bench for the EAN-13 / UPC-A / EAN-8 / UPC-E bar-module encoder.
// Depends on ean_pkg and ean_upc_barcode_module_encoder_core, and so on ean_ctrl and ean_datapath.
// Drives digit beats, predicts every module group and compares each result beat.
module tb_top;
  import ean_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned RandomDigits  = 110;

  // digit patterns, index = digit value
  localparam logic [0:9][6:0] LPAT = {7'h0D, 7'h19, 7'h13, 7'h3D, 7'h23,
                                      7'h31, 7'h2F, 7'h3B, 7'h37, 7'h0B};
  localparam logic [0:9][6:0] GPAT = {7'h27, 7'h33, 7'h1B, 7'h21, 7'h1D,
                                      7'h39, 7'h05, 7'h11, 7'h09, 7'h17};
  localparam logic [0:9][6:0] RPAT = {7'h72, 7'h66, 7'h6C, 7'h42, 7'h5C,
                                      7'h4E, 7'h50, 7'h44, 7'h48, 7'h74};
  // 1 = G pattern, bit 5 = first left digit
  localparam logic [0:9][5:0] EAN_PARITY  = {6'h00, 6'h0B, 6'h0D, 6'h0E, 6'h13,
                                             6'h19, 6'h1C, 6'h15, 6'h16, 6'h1A};
  localparam logic [0:9][5:0] UPCE_PARITY = {6'h38, 6'h34, 6'h32, 6'h31, 6'h2C,
                                             6'h26, 6'h23, 6'h2A, 6'h29, 6'h25};

  typedef struct packed {
    logic [6:0] mods;
    logic [2:0] cnt;
    logic       full;
    status_e    status;
    logic [3:0] chk;
    logic       last;
  } group_t;

  typedef struct packed {
    sym_e       sym;
    logic [3:0] digit;
    logic       last;
    logic       typed;   // error beat given below instead of predicted
    status_e    status;
    logic [3:0] chk;
  } row_t;

  localparam row_t [0:24] DIRECTED_ROWS = '{
    '{SYM_EAN13, 4'd15, 1'b1, 1'b1, ST_BAD_LEN,   4'd0},
    '{SYM_EAN8,  4'd0,  1'b0, 1'b0, ST_OK,        4'd0},
    '{SYM_EAN8,  4'd0,  1'b0, 1'b0, ST_OK,        4'd0},
    '{SYM_EAN8,  4'd0,  1'b0, 1'b0, ST_OK,        4'd0},
    '{SYM_EAN8,  4'd0,  1'b0, 1'b0, ST_OK,        4'd0},
    '{SYM_EAN8,  4'd0,  1'b0, 1'b0, ST_OK,        4'd0},
    '{SYM_EAN8,  4'd0,  1'b0, 1'b0, ST_OK,        4'd0},
    '{SYM_EAN8,  4'd0,  1'b0, 1'b0, ST_OK,        4'd0},
    '{SYM_EAN8,  4'd5,  1'b1, 1'b1, ST_MISMATCH,  4'd0},
    '{SYM_UPCE,  4'd1,  1'b0, 1'b0, ST_OK,        4'd0},
    '{SYM_UPCE,  4'd9,  1'b0, 1'b0, ST_OK,        4'd0},
    '{SYM_UPCE,  4'd9,  1'b0, 1'b0, ST_OK,        4'd0},
    '{SYM_UPCE,  4'd9,  1'b0, 1'b0, ST_OK,        4'd0},
    '{SYM_UPCE,  4'd9,  1'b0, 1'b0, ST_OK,        4'd0},
    '{SYM_UPCE,  4'd9,  1'b0, 1'b0, ST_OK,        4'd0},
    '{SYM_UPCE,  4'd9,  1'b0, 1'b0, ST_OK,        4'd0},
    '{SYM_UPCE,  4'd9,  1'b1, 1'b0, ST_OK,        4'd0},
    '{SYM_UPCE,  4'd2,  1'b0, 1'b0, ST_OK,        4'd0},
    '{SYM_UPCE,  4'd0,  1'b0, 1'b0, ST_OK,        4'd0},
    '{SYM_UPCE,  4'd0,  1'b0, 1'b0, ST_OK,        4'd0},
    '{SYM_UPCE,  4'd0,  1'b0, 1'b0, ST_OK,        4'd0},
    '{SYM_UPCE,  4'd0,  1'b0, 1'b0, ST_OK,        4'd0},
    '{SYM_UPCE,  4'd0,  1'b0, 1'b0, ST_OK,        4'd0},
    '{SYM_UPCE,  4'd0,  1'b0, 1'b0, ST_OK,        4'd0},
    '{SYM_UPCE,  4'd0,  1'b1, 1'b1, ST_BAD_SYS,   4'd0}
  };

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic [3:0] digit;
  logic       last_digit;
  logic       sym_we;
  logic [1:0] sym_val;
  logic       result_valid;
  logic [6:0] modules;
  logic [2:0] module_count;
  logic       full_height;
  logic [2:0] status;
  logic [3:0] check_value;
  logic       last_group;

  ean_upc_barcode_module_encoder_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_o         (busy),
    .digit_i        (digit),
    .last_digit_i   (last_digit),
    .symbology_we_i (sym_we),
    .symbology_i    (sym_val),
    .result_valid_o (result_valid),
    .modules_o      (modules),
    .module_count_o (module_count),
    .full_height_o  (full_height),
    .status_o       (status),
    .check_value_o  (check_value),
    .last_group_o   (last_group)
  );

  // encoder state as the bench sees it
  sym_e             symbology_now = SYM_EAN13;
  logic [12:0][3:0] digit_store;
  logic [3:0]       digit_count = '0;
  logic             saw_non_digit = 1'b0;

  group_t      symbol_groups[$];   // groups built from the latest digit beat
  group_t      pending_groups[$];  // groups still owed by the block
  int unsigned mismatches = 0;
  int unsigned beats_seen = 0;
  int unsigned random_digits = 0;
  int unsigned idle_cycles = 0;
  logic        steady = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [3:0] check_digit(input logic [12:0][3:0] v, input int n,
                                             input int w_odd, input int w_even);
    int acc;
    acc = 0;
    for (int i = 0; i < n; i++) acc += int'(v[i]) * ((i % 2) ? w_odd : w_even);
    acc = acc % 10;
    return (acc != 0) ? 4'(10 - acc) : 4'd0;
  endfunction

  task automatic put_group(input logic [6:0] m, input logic [2:0] c, input logic f,
                           input logic [3:0] chk, input logic lst);
    symbol_groups.push_back('{m, c, f, ST_OK, chk, lst});
  endtask

  task automatic put_error(input status_e st, input logic [3:0] chk);
    symbol_groups.push_back('{7'd0, 3'd0, 1'b0, st, chk, 1'b1});
  endtask

  task automatic build_symbol();
    int               n;
    logic [12:0][3:0] v;
    logic [3:0]       chk;
    logic [5:0]       mask;
    logic             upca;
    logic             len_ok;
    n = int'(digit_count);
    v = '0;
    upca = (symbology_now == SYM_UPCA);
    case (symbology_now)
      SYM_EAN13: len_ok = (n == 12 || n == 13);
      SYM_UPCA:  len_ok = (n == 11 || n == 12);
      SYM_EAN8:  len_ok = (n == 7 || n == 8);
      default:   len_ok = (n == 8);
    endcase
    if (!len_ok) begin
      put_error(ST_BAD_LEN, 4'd0);
    end else if (saw_non_digit) begin
      put_error(ST_NON_DIGIT, 4'd0);
    end else if (symbology_now == SYM_EAN8) begin
      for (int i = 0; i < 7; i++) v[i] = digit_store[i];
      chk = check_digit(v, 7, 1, 3);
      if (n == 8 && digit_store[7] != chk) begin
        put_error(ST_MISMATCH, chk);
      end else begin
        v[7] = chk;
        put_group(GuardPat, GuardCnt, 1'b1, chk, 1'b0);
        for (int i = 0; i < 4; i++) put_group(LPAT[v[i]], DigitCnt, 1'b0, chk, 1'b0);
        put_group(CenterPat, CenterCnt, 1'b1, chk, 1'b0);
        for (int i = 4; i < 8; i++) put_group(RPAT[v[i]], DigitCnt, 1'b0, chk, 1'b0);
        put_group(GuardPat, GuardCnt, 1'b1, chk, 1'b1);
      end
    end else if (symbology_now == SYM_UPCE) begin
      if (digit_store[0] > 4'd1) begin
        put_error(ST_BAD_SYS, 4'd0);
      end else begin
        // check digit is taken as given and only steers the parity
        chk = digit_store[7];
        mask = UPCE_PARITY[chk];
        if (digit_store[0] == 4'd1) mask = ~mask;
        put_group(GuardPat, GuardCnt, 1'b1, chk, 1'b0);
        for (int i = 0; i < 6; i++)
          put_group(mask[5-i] ? GPAT[digit_store[i+1]] : LPAT[digit_store[i+1]],
                    DigitCnt, 1'b0, chk, 1'b0);
        put_group(UpceEndPat, UpceEndCnt, 1'b1, chk, 1'b1);
      end
    end else begin
      // UPC-A is EAN-13 with a leading zero
      if (upca) begin
        for (int i = 0; i < 11; i++) v[i+1] = digit_store[i];
      end else begin
        for (int i = 0; i < 12; i++) v[i] = digit_store[i];
      end
      chk = check_digit(v, 12, 3, 1);
      if ((upca && n == 12 && digit_store[11] != chk) ||
          (!upca && n == 13 && digit_store[12] != chk)) begin
        put_error(ST_MISMATCH, chk);
      end else begin
        v[12] = chk;
        mask = EAN_PARITY[v[0]];
        put_group(GuardPat, GuardCnt, 1'b1, chk, 1'b0);
        for (int i = 0; i < 6; i++)
          put_group(mask[5-i] ? GPAT[v[i+1]] : LPAT[v[i+1]], DigitCnt,
                    upca && i == 0, chk, 1'b0);
        put_group(CenterPat, CenterCnt, 1'b1, chk, 1'b0);
        for (int i = 0; i < 6; i++)
          put_group(RPAT[v[i+7]], DigitCnt, upca && i == 5, chk, 1'b0);
        put_group(GuardPat, GuardCnt, 1'b1, chk, 1'b1);
      end
    end
  endtask

  task automatic absorb_digit(input logic [3:0] d, input logic lst);
    symbol_groups.delete();
    if (digit_count < 4'd13) digit_store[digit_count] = d;
    if (digit_count < 4'd15) digit_count = digit_count + 4'd1;
    if (d > 4'd9) saw_non_digit = 1'b1;
    if (lst) begin
      build_symbol();
      digit_count = '0;
      saw_non_digit = 1'b0;
    end
  endtask

  task automatic send_digit(input logic [3:0] d, input logic lst, input logic typed,
                            input group_t typed_grp);
    // randomly hold off before presenting the digit, unless steady
    while (!steady && $urandom_range(99) < 38) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    digit <= d;
    last_digit <= lst;
    do @(posedge clk_i); while (busy !== 1'b0);
    absorb_digit(d, lst);
    if (typed) begin
      pending_groups.push_back(typed_grp);
    end else begin
      foreach (symbol_groups[k]) pending_groups.push_back(symbol_groups[k]);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_groups.size() != 0) @(posedge clk_i);
    // let the block settle before touching its register
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_symbology(input sym_e s);
    sym_we <= 1'b1;
    sym_val <= s;
    @(posedge clk_i);
    symbology_now = s;
    sym_we <= 1'b0;
  endtask

  task automatic send_number(input sym_e s);
    logic [3:0]       ds [0:19];
    logic [12:0][3:0] v;
    int               len;
    int               kind;
    kind = $urandom_range(99);
    v = '0;
    case (s)
      SYM_EAN13: len = $urandom_range(12, 13);
      SYM_UPCA:  len = $urandom_range(11, 12);
      SYM_EAN8:  len = $urandom_range(7, 8);
      default:   len = 8;
    endcase
    for (int i = 0; i < 20; i++) ds[i] = 4'($urandom_range(0, 9));
    if (s == SYM_UPCE) ds[0] = 4'($urandom_range(0, 1));
    if (kind < 60) begin
      // supply a correct check digit where the length carries one
      case (s)
        SYM_EAN13: if (len == 13) begin
          for (int i = 0; i < 12; i++) v[i] = ds[i];
          ds[12] = check_digit(v, 12, 3, 1);
        end
        SYM_UPCA: if (len == 12) begin
          for (int i = 0; i < 11; i++) v[i+1] = ds[i];
          ds[11] = check_digit(v, 12, 3, 1);
        end
        SYM_EAN8: if (len == 8) begin
          for (int i = 0; i < 7; i++) v[i] = ds[i];
          ds[7] = check_digit(v, 7, 1, 3);
        end
        default: ;
      endcase
    end else if (kind >= 75 && kind < 88) begin
      if (s == SYM_UPCE && $urandom_range(1) == 1) ds[0] = 4'($urandom_range(2, 9));
      else ds[$urandom_range(0, len - 1)] = 4'($urandom_range(10, 15));
    end else if (kind >= 88) begin
      // noise, often long enough to saturate the count
      len = ($urandom_range(1) == 1) ? $urandom_range(14, 20) : $urandom_range(1, 20);
      for (int i = 0; i < len; i++) ds[i] = 4'($urandom_range(0, 15));
    end
    for (int i = 0; i < len; i++) begin
      steady = (random_digits >= 50 && random_digits < 100);
      send_digit(ds[i], i == len - 1, 1'b0, '0);
      random_digits++;
    end
  endtask

  task automatic report_mismatch(input string what, input group_t want, input group_t got);
    if (mismatches < 10) begin
      $display("%0t beat %0d %s", $time, beats_seen, what);
      $display("  want mods=%h cnt=%0d full=%0d status=%0d chk=%0d last=%0d",
               want.mods, want.cnt, want.full, want.status, want.chk, want.last);
      $display("  got  mods=%h cnt=%0d full=%0d status=%0d chk=%0d last=%0d",
               got.mods, got.cnt, got.full, got.status, got.chk, got.last);
    end
    mismatches++;
  endtask

  always @(posedge clk_i) begin : check_results
    group_t want;
    group_t got;
    if (rst_ni && result_valid === 1'b1) begin
      got = '{modules, module_count, full_height, status_e'(status), check_value,
              last_group};
      if (pending_groups.size() == 0) begin
        report_mismatch("unexpected", '0, got);
      end else begin
        want = pending_groups.pop_front();
        if (got.mods !== want.mods || got.cnt !== want.cnt || got.full !== want.full ||
            got.status !== want.status || got.chk !== want.chk ||
            got.last !== want.last)
          report_mismatch("wrong field", want, got);
      end
      beats_seen++;
    end
  end

  // count cycles in which neither a digit nor a result beat moves
  always @(posedge clk_i) begin
    if ((start === 1'b1 && busy === 1'b0) || result_valid === 1'b1) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("ean_upc_barcode_module_encoder_core: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    row_t   row;
    group_t typed_grp;
    logic   number_start;
    int     phase;
    rst_ni <= 1'b0;
    start <= 1'b0;
    digit <= '0;
    last_digit <= 1'b0;
    sym_we <= 1'b0;
    sym_val <= SYM_EAN13;
    number_start = 1'b1;
    phase = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 25; i++) begin
      row = DIRECTED_ROWS[i];
      if (number_start && row.sym != symbology_now) begin
        wait_drained();
        write_symbology(row.sym);
      end
      typed_grp = '{7'd0, 3'd0, 1'b0, row.status, row.chk, 1'b1};
      send_digit(row.digit, row.last, row.typed, typed_grp);
      number_start = row.last;
    end

    while (random_digits < RandomDigits) begin
      // hold until every group is out, then switch symbology
      wait_drained();
      write_symbology((phase < 4) ? sym_e'(phase) : sym_e'($urandom_range(0, 3)));
      repeat ($urandom_range(2, 4)) send_number(symbology_now);
      phase++;
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_groups.size() == 0) begin
      $display("ean_upc_barcode_module_encoder_core: match");
    end else begin
      $display("ean_upc_barcode_module_encoder_core: mismatch");
    end
    $finish;
  end

endmodule

// File: ean_upc_barcode_module_encoder_core.f
rtl/core/ean_pkg.sv
rtl/core/ean_ctrl.sv
rtl/core/ean_datapath.sv
rtl/core/ean_upc_barcode_module_encoder_core.sv
tb/tb_top.sv
